[hw/rtl/wsd_pkg.sv]
// Shared types and codes for the WebSocket frame deframer.
// Used by the parser core, the result queue and the top level; no dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_CLOSE   = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_RSV        = 4'd1;
    localparam logic [3:0] ERR_MASK       = 4'd2;
    localparam logic [3:0] ERR_OPCODE     = 4'd3;
    localparam logic [3:0] ERR_LEN_MSB    = 4'd4;
    localparam logic [3:0] ERR_NONMINIMAL = 4'd5;
    localparam logic [3:0] ERR_CONTROL    = 4'd6;
    localparam logic [3:0] ERR_LARGE      = 4'd7;
    localparam logic [3:0] ERR_FRAG       = 4'd8;
    localparam logic [3:0] ERR_CLOSE_LEN1 = 4'd9;
    localparam logic [3:0] ERR_CODE       = 4'd10;
    localparam logic [3:0] ERR_UTF8       = 4'd11;

    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic       CFG_ROLE    = 1'b0;
    localparam logic       CFG_MAX_LEN = 1'b1;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  opcode;
        logic        final_flag;
        logic [7:0]  payload_byte;
        logic [62:0] frame_length;
        logic        last_of_frame;
        logic [3:0]  error_code;
        logic [15:0] close_status;
    } res_t;

endpackage

[hw/rtl/wsd_core.sv]
// Frame parser state and per-byte next-state logic for the deframer.
// Depends on wsd_pkg; produces up to two results per accepted transaction.
`timescale 1ns / 1ps

module wsd_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              restart,
    input  logic              role_is_server,
    input  logic [62:0]       max_payload_bytes,
    output logic [1:0]        res_count,
    output wsd_pkg::res_t     res0,
    output wsd_pkg::res_t     res1
);

    typedef enum logic [5:0] {
        PH_HDR1  = 6'b000001,
        PH_HDR2  = 6'b000010,
        PH_EXT16 = 6'b000100,
        PH_EXT64 = 6'b001000,
        PH_MASK  = 6'b010000,
        PH_DATA  = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN    = 3'b001,
        ST_CLOSED = 3'b010,
        ST_ERROR  = 3'b100
    } sticky_t;

    phase_t      phase_reg, phase_next;
    sticky_t     sticky_reg, sticky_next;
    logic [4:0]  hf_reg, hf_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [62:0] remain_reg, remain_next;
    logic [1:0]  midx_reg, midx_next;
    logic [15:0] code_reg, code_next;
    logic [2:0]  utf_reg, utf_next;

    function automatic logic close_code_ok(input logic [15:0] c);
        logic ok;
        begin
            if (c >= 16'd3000 && c <= 16'd4999)
                ok = 1'b1;
            else if (c < 16'd1000 || c > 16'd1014)
                ok = 1'b0;
            else
                ok = (c != 16'd1004) && (c != 16'd1005) && (c != 16'd1006);
            return ok;
        end
    endfunction

    // Returns {accepted, next pending state}.
    function automatic logic [3:0] utf8_step(input logic [2:0] p, input logic [7:0] b);
        logic [3:0] r;
        begin
            r = 4'b0000;
            case (p)
                3'd0:
                begin
                    if (b <= 8'h7f) r = {1'b1, 3'd0};
                    else if (b >= 8'hc2 && b <= 8'hdf) r = {1'b1, 3'd1};
                    else if (b == 8'he0) r = {1'b1, 3'd4};
                    else if (b == 8'hed) r = {1'b1, 3'd5};
                    else if (b >= 8'he1 && b <= 8'hef) r = {1'b1, 3'd2};
                    else if (b == 8'hf0) r = {1'b1, 3'd6};
                    else if (b == 8'hf4) r = {1'b1, 3'd7};
                    else if (b >= 8'hf1 && b <= 8'hf3) r = {1'b1, 3'd3};
                end
                3'd1, 3'd2, 3'd3:
                begin
                    if (b >= 8'h80 && b <= 8'hbf) r = {1'b1, p - 3'd1};
                end
                3'd4:
                begin
                    if (b >= 8'ha0 && b <= 8'hbf) r = {1'b1, 3'd1};
                end
                3'd5:
                begin
                    if (b >= 8'h80 && b <= 8'h9f) r = {1'b1, 3'd1};
                end
                3'd6:
                begin
                    if (b >= 8'h90 && b <= 8'hbf) r = {1'b1, 3'd2};
                end
                3'd7:
                begin
                    if (b >= 8'h80 && b <= 8'h8f) r = {1'b1, 3'd2};
                end
                default: r = 4'b0000;
            endcase
            return r;
        end
    endfunction

    logic        pre_en, fail_en, fin_en, beg_en, close_en;
    logic [3:0]  fail_code;
    logic [63:0] fin_len;
    logic [62:0] beg_len;
    logic [15:0] close_val;
    logic [7:0]  mbyte, pv;
    logic        last_b;
    logic [3:0]  cnt_inc;
    logic [3:0]  ustep;
    wsd_pkg::res_t r_pre, r_fail, r_hdr, r_close;

    always_comb
    begin
        phase_next  = phase_reg;
        sticky_next = sticky_reg;
        hf_next     = hf_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        midx_next   = midx_reg;
        code_next   = code_reg;
        utf_next    = utf_reg;
        pre_en = 1'b0;
        fail_en = 1'b0;
        fin_en = 1'b0;
        beg_en = 1'b0;
        close_en = 1'b0;
        fail_code = wsd_pkg::ERR_NONE;
        fin_len = 64'd0;
        beg_len = 63'd0;
        close_val = 16'd0;
        cnt_inc = cnt_reg + 4'd1;
        ustep = 4'd0;
        case (midx_reg)
            2'd0: mbyte = key_reg[31:24];
            2'd1: mbyte = key_reg[23:16];
            2'd2: mbyte = key_reg[15:8];
            default: mbyte = key_reg[7:0];
        endcase
        pv = data_byte ^ (role_is_server ? mbyte : 8'h00);
        last_b = (remain_reg[62:1] == 62'd0);

        if (step && restart)
        begin
            sticky_next = ST_RUN;
            phase_next  = PH_HDR1;
        end
        else if (step && sticky_reg == ST_RUN)
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    if (data_byte[7] != role_is_server)
                    begin
                        fail_en = 1'b1;
                        fail_code = wsd_pkg::ERR_MASK;
                    end
                    else if (!(hf_reg[3:0] == wsd_pkg::OP_TEXT ||
                               hf_reg[3:0] == wsd_pkg::OP_CLOSE ||
                               hf_reg[3:0] == wsd_pkg::OP_PING ||
                               hf_reg[3:0] == wsd_pkg::OP_PONG))
                    begin
                        fail_en = 1'b1;
                        fail_code = wsd_pkg::ERR_OPCODE;
                    end
                    else
                    begin
                        len_next = 64'd0;
                        cnt_next = 4'd0;
                        if (data_byte[6:0] == 7'd126)
                            phase_next = PH_EXT16;
                        else if (data_byte[6:0] == 7'd127)
                            phase_next = PH_EXT64;
                        else
                        begin
                            len_next = {57'd0, data_byte[6:0]};
                            fin_en = 1'b1;
                            fin_len = {57'd0, data_byte[6:0]};
                        end
                    end
                end
                PH_EXT16:
                begin
                    len_next = {48'd0, len_reg[7:0], data_byte};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd2)
                    begin
                        if (len_next < 64'd126)
                        begin
                            fail_en = 1'b1;
                            fail_code = wsd_pkg::ERR_NONMINIMAL;
                        end
                        else
                        begin
                            fin_en = 1'b1;
                            fin_len = len_next;
                        end
                    end
                end
                PH_EXT64:
                begin
                    if (cnt_reg == 4'd0 && data_byte[7])
                    begin
                        fail_en = 1'b1;
                        fail_code = wsd_pkg::ERR_LEN_MSB;
                    end
                    else
                    begin
                        len_next = {len_reg[55:0], data_byte};
                        cnt_next = cnt_inc;
                        if (cnt_inc >= 4'd8)
                        begin
                            if (len_next <= 64'h0000_0000_0000_ffff)
                            begin
                                fail_en = 1'b1;
                                fail_code = wsd_pkg::ERR_NONMINIMAL;
                            end
                            else
                            begin
                                fin_en = 1'b1;
                                fin_len = len_next;
                            end
                        end
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], data_byte};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd4)
                    begin
                        beg_en = 1'b1;
                        beg_len = remain_reg;
                    end
                end
                PH_DATA:
                begin
                    pre_en = 1'b1;
                    midx_next = midx_reg + 2'd1;
                    remain_next = last_b ? 63'd0 : remain_reg - 63'd1;
                    if (hf_reg[3:0] == wsd_pkg::OP_CLOSE)
                    begin
                        if (cnt_reg < 4'd2)
                        begin
                            code_next = {code_reg[7:0], pv};
                            cnt_next = cnt_inc;
                            if (cnt_inc == 4'd2 && !close_code_ok(code_next))
                            begin
                                fail_en = 1'b1;
                                fail_code = wsd_pkg::ERR_CODE;
                            end
                        end
                        else
                        begin
                            ustep = utf8_step(utf_reg, pv);
                            utf_next = ustep[2:0];
                            if (!ustep[3])
                            begin
                                fail_en = 1'b1;
                                fail_code = wsd_pkg::ERR_UTF8;
                            end
                        end
                        if (!fail_en && last_b)
                        begin
                            if (cnt_next == 4'd1)
                            begin
                                fail_en = 1'b1;
                                fail_code = wsd_pkg::ERR_CLOSE_LEN1;
                            end
                            else if (utf_next != 3'd0)
                            begin
                                fail_en = 1'b1;
                                fail_code = wsd_pkg::ERR_UTF8;
                            end
                            else
                            begin
                                close_en = 1'b1;
                                close_val = (cnt_next == 4'd2) ? code_next : 16'd0;
                                sticky_next = ST_CLOSED;
                            end
                        end
                    end
                    if (last_b)
                        phase_next = PH_HDR1;
                end
                default:
                begin
                    hf_next = {data_byte[7], data_byte[3:0]};
                    if ((data_byte & 8'h70) != 8'h00)
                    begin
                        fail_en = 1'b1;
                        fail_code = wsd_pkg::ERR_RSV;
                    end
                    else
                        phase_next = PH_HDR2;
                end
            endcase

            if (fin_en)
            begin
                if (hf_reg[3] && (!hf_reg[4] || fin_len > 64'd125))
                begin
                    fail_en = 1'b1;
                    fail_code = wsd_pkg::ERR_CONTROL;
                end
                else if (fin_len > {1'b0, max_payload_bytes})
                begin
                    fail_en = 1'b1;
                    fail_code = wsd_pkg::ERR_LARGE;
                end
                else if (!hf_reg[3] && !hf_reg[4])
                begin
                    fail_en = 1'b1;
                    fail_code = wsd_pkg::ERR_FRAG;
                end
                else
                begin
                    remain_next = fin_len[62:0];
                    if (role_is_server)
                    begin
                        phase_next = PH_MASK;
                        cnt_next = 4'd0;
                        key_next = 32'd0;
                    end
                    else
                    begin
                        beg_en = 1'b1;
                        beg_len = fin_len[62:0];
                    end
                end
            end

            if (beg_en)
            begin
                midx_next = 2'd0;
                cnt_next = 4'd0;
                code_next = 16'd0;
                utf_next = 3'd0;
                if (beg_len != 63'd0)
                    phase_next = PH_DATA;
                else
                begin
                    phase_next = PH_HDR1;
                    if (hf_reg[3:0] == wsd_pkg::OP_CLOSE)
                    begin
                        sticky_next = ST_CLOSED;
                        close_en = 1'b1;
                        close_val = 16'd0;
                    end
                end
            end

            if (fail_en)
            begin
                sticky_next = ST_ERROR;
                phase_next = PH_HDR1;
            end
        end
    end

    always_comb
    begin
        r_pre = '0;
        r_pre.kind = wsd_pkg::KIND_PAYLOAD;
        r_pre.opcode = hf_reg[3:0];
        r_pre.final_flag = hf_reg[4];
        r_pre.payload_byte = pv;
        r_pre.last_of_frame = last_b;

        r_fail = '0;
        r_fail.kind = wsd_pkg::KIND_ERROR;
        r_fail.opcode = hf_next[3:0];
        r_fail.final_flag = hf_next[4];
        r_fail.error_code = fail_code;

        r_hdr = '0;
        r_hdr.kind = wsd_pkg::KIND_HEADER;
        r_hdr.opcode = hf_reg[3:0];
        r_hdr.final_flag = hf_reg[4];
        r_hdr.frame_length = beg_len;
        r_hdr.last_of_frame = (beg_len == 63'd0);

        r_close = '0;
        r_close.kind = wsd_pkg::KIND_CLOSE;
        r_close.opcode = wsd_pkg::OP_CLOSE;
        r_close.final_flag = 1'b1;
        r_close.close_status = close_val;

        res0 = '0;
        res1 = '0;
        res_count = 2'd0;
        if (pre_en)
        begin
            res0 = r_pre;
            res_count = 2'd1;
            if (fail_en)
            begin
                res1 = r_fail;
                res_count = 2'd2;
            end
            else if (close_en)
            begin
                res1 = r_close;
                res_count = 2'd2;
            end
        end
        else if (fail_en)
        begin
            res0 = r_fail;
            res_count = 2'd1;
        end
        else if (beg_en)
        begin
            res0 = r_hdr;
            res_count = 2'd1;
            if (close_en)
            begin
                res1 = r_close;
                res_count = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            sticky_reg <= ST_RUN;
            hf_reg     <= 5'd0;
            len_reg    <= 64'd0;
            cnt_reg    <= 4'd0;
            key_reg    <= 32'd0;
            remain_reg <= 63'd0;
            midx_reg   <= 2'd0;
            code_reg   <= 16'd0;
            utf_reg    <= 3'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sticky_reg <= sticky_next;
            hf_reg     <= hf_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            midx_reg   <= midx_next;
            code_reg   <= code_next;
            utf_reg    <= utf_next;
        end
    end

endmodule

[hw/rtl/wsd_outq.sv]
// Four-entry result queue that takes up to two results per cycle.
// Depends on wsd_pkg for the result type.
`timescale 1ns / 1ps

module wsd_outq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  wsd_pkg::res_t push0,
    input  wsd_pkg::res_t push1,
    output logic          full2,
    output logic          out_valid,
    input  logic          out_stall,
    output wsd_pkg::res_t out_res
);

    wsd_pkg::res_t mem [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_res   = mem[rptr_reg];
    assign full2     = (count_reg > 3'd2);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wptr_next  = wptr_reg + push_count;
        rptr_next  = rptr_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push_count} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wptr_reg] <= push0;
        if (push_count == 2'd2)
            mem[wptr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// Top level: WebSocket receive deframer, one stream byte per transaction.
// A result is queued when its byte is accepted, behind any earlier results.
// Throughput: one byte per cycle; the parser advances on each accepted byte;
// the four-entry result queue stalls input only when fewer than two slots are free.
// Reset clears parser state and queue; role is server, size limit 8388608 bytes.
`timescale 1ns / 1ps

module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [3:0]  opcode,
    output logic        final_flag,
    output logic [7:0]  payload_byte,
    output logic [62:0] frame_length,
    output logic        last_of_frame,
    output logic [3:0]  error_code,
    output logic [15:0] close_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [62:0] cfg_data
);

    logic          role_reg;
    logic [62:0]   max_reg;
    logic          step;
    logic [1:0]    res_count;
    wsd_pkg::res_t res0, res1, out_res;

    assign cfg_ready = 1'b1;
    assign step = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg <= 1'b1;
            max_reg  <= 63'd8388608;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == wsd_pkg::CFG_ROLE)
                role_reg <= cfg_data[0];
            else
                max_reg <= cfg_data;
        end
    end

    wsd_core u_core
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .data_byte         (data_byte),
        .restart           (restart),
        .role_is_server    (role_reg),
        .max_payload_bytes (max_reg),
        .res_count         (res_count),
        .res0              (res0),
        .res1              (res1)
    );

    wsd_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .full2      (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    assign kind          = out_res.kind;
    assign opcode        = out_res.opcode;
    assign final_flag    = out_res.final_flag;
    assign payload_byte  = out_res.payload_byte;
    assign frame_length  = out_res.frame_length;
    assign last_of_frame = out_res.last_of_frame;
    assign error_code    = out_res.error_code;
    assign close_status  = out_res.close_status;

endmodule

[tb/tb.sv]
// Self-checking WebSocket deframer testbench: directed table, random frames, 64-bit length.
// A behavioral frame parser in this file predicts every result; depends on wsd_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       rst;
        logic       has_exp;
        logic [1:0] exp_kind;
        logic [3:0] exp_err;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic        final_flag;
    logic [7:0]  payload_byte;
    logic [62:0] frame_length;
    logic        last_of_frame;
    logic [3:0]  error_code;
    logic [15:0] close_status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [62:0] cfg_data;

    wsd_pkg::res_t expected_events[$];
    int    failures;
    int    n_pushed;
    bit    rx_no_idle;
    bit    rx_hold;
    bit    tx_no_idle;
    byte unsigned frame_bytes[$];

    logic        srv_role;
    logic [62:0] size_limit;
    logic [2:0]  phase;
    logic [1:0]  status;
    logic [4:0]  hdr_first;
    logic [63:0] len_acc;
    logic [3:0]  len_cnt;
    logic [31:0] key;
    logic [62:0] remain;
    logic [1:0]  key_idx;
    logic [15:0] code_acc;
    logic [3:0]  u8_state;

    localparam logic [2:0] P_HDR1 = 3'd0, P_HDR2 = 3'd1, P_EXT16 = 3'd2,
                           P_EXT64 = 3'd3, P_KEY = 3'd4, P_DATA = 3'd5;
    localparam logic [1:0] S_RUN = 2'd0, S_CLOSED = 2'd1, S_ERR = 2'd2;

    websocket_frame_deframer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("websocket_frame_deframer regression: fail");
        $finish;
    end

    function automatic void push_event(wsd_pkg::kind_t k, logic [3:0] op, logic fin,
                                       logic [7:0] pb, logic [62:0] len, logic last,
                                       logic [3:0] err, logic [15:0] st);
        wsd_pkg::res_t r;
        r.kind = k;
        r.opcode = op;
        r.final_flag = fin;
        r.payload_byte = pb;
        r.frame_length = len;
        r.last_of_frame = last;
        r.error_code = err;
        r.close_status = st;
        expected_events = {expected_events, r};
        n_pushed++;
    endfunction

    function automatic void parse_error(logic [3:0] code);
        status = S_ERR;
        phase = P_HDR1;
        push_event(wsd_pkg::KIND_ERROR, hdr_first[3:0], hdr_first[4], 8'd0, 63'd0, 1'b0,
                   code, 16'd0);
    endfunction

    function automatic bit close_code_valid(logic [15:0] c);
        if (c >= 16'd3000 && c <= 16'd4999)
            return 1'b1;
        if (c < 16'd1000 || c > 16'd1014)
            return 1'b0;
        return c != 16'd1004 && c != 16'd1005 && c != 16'd1006;
    endfunction

    function automatic bit utf8_accept(logic [7:0] b);
        case (u8_state)
            4'd0:
            begin
                if (b <= 8'h7f) return 1'b1;
                if (b >= 8'hc2 && b <= 8'hdf) begin u8_state = 4'd1; return 1'b1; end
                if (b == 8'he0) begin u8_state = 4'd4; return 1'b1; end
                if (b == 8'hed) begin u8_state = 4'd5; return 1'b1; end
                if (b >= 8'he1 && b <= 8'hef) begin u8_state = 4'd2; return 1'b1; end
                if (b == 8'hf0) begin u8_state = 4'd6; return 1'b1; end
                if (b == 8'hf4) begin u8_state = 4'd7; return 1'b1; end
                if (b >= 8'hf1 && b <= 8'hf3) begin u8_state = 4'd3; return 1'b1; end
                return 1'b0;
            end
            4'd1, 4'd2, 4'd3:
            begin
                if (b < 8'h80 || b > 8'hbf) return 1'b0;
                u8_state = u8_state - 4'd1;
                return 1'b1;
            end
            4'd4:
            begin
                if (b < 8'ha0 || b > 8'hbf) return 1'b0;
                u8_state = 4'd1;
                return 1'b1;
            end
            4'd5:
            begin
                if (b < 8'h80 || b > 8'h9f) return 1'b0;
                u8_state = 4'd1;
                return 1'b1;
            end
            4'd6:
            begin
                if (b < 8'h90 || b > 8'hbf) return 1'b0;
                u8_state = 4'd2;
                return 1'b1;
            end
            4'd7:
            begin
                if (b < 8'h80 || b > 8'h8f) return 1'b0;
                u8_state = 4'd2;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void open_payload();
        logic [3:0] op;
        op = hdr_first[3:0];
        key_idx = 2'd0;
        len_cnt = 4'd0;
        code_acc = 16'd0;
        u8_state = 4'd0;
        push_event(wsd_pkg::KIND_HEADER, op, hdr_first[4], 8'd0, remain, remain == 63'd0,
                   wsd_pkg::ERR_NONE, 16'd0);
        if (remain != 63'd0)
        begin
            phase = P_DATA;
            return;
        end
        phase = P_HDR1;
        if (op == wsd_pkg::OP_CLOSE)
        begin
            status = S_CLOSED;
            push_event(wsd_pkg::KIND_CLOSE, wsd_pkg::OP_CLOSE, 1'b1, 8'd0, 63'd0, 1'b0,
                       wsd_pkg::ERR_NONE, 16'd0);
        end
    endfunction

    function automatic void check_header();
        logic ctrl;
        ctrl = hdr_first[3];
        if (ctrl && (!hdr_first[4] || len_acc > 64'd125))
        begin
            parse_error(wsd_pkg::ERR_CONTROL);
            return;
        end
        if (len_acc > {1'b0, size_limit})
        begin
            parse_error(wsd_pkg::ERR_LARGE);
            return;
        end
        if (!ctrl && !hdr_first[4])
        begin
            parse_error(wsd_pkg::ERR_FRAG);
            return;
        end
        remain = len_acc[62:0];
        if (srv_role)
        begin
            phase = P_KEY;
            len_cnt = 4'd0;
            key = 32'd0;
        end
        else
            open_payload();
    endfunction

    function automatic void take_payload(logic [7:0] b);
        logic [3:0] op;
        logic [7:0] v;
        logic       last;
        op = hdr_first[3:0];
        v = b ^ (srv_role ? key[31 - 8 * key_idx -: 8] : 8'd0);
        last = remain <= 63'd1;
        push_event(wsd_pkg::KIND_PAYLOAD, op, hdr_first[4], v, 63'd0, last,
                   wsd_pkg::ERR_NONE, 16'd0);
        key_idx = key_idx + 2'd1;
        remain = last ? 63'd0 : remain - 63'd1;
        if (op == wsd_pkg::OP_CLOSE)
        begin
            if (len_cnt < 4'd2)
            begin
                code_acc = {code_acc[7:0], v};
                len_cnt = len_cnt + 4'd1;
                if (len_cnt == 4'd2 && !close_code_valid(code_acc))
                begin
                    parse_error(wsd_pkg::ERR_CODE);
                    return;
                end
            end
            else if (!utf8_accept(v))
            begin
                parse_error(wsd_pkg::ERR_UTF8);
                return;
            end
            if (last)
            begin
                if (len_cnt == 4'd1)
                    parse_error(wsd_pkg::ERR_CLOSE_LEN1);
                else if (u8_state != 4'd0)
                    parse_error(wsd_pkg::ERR_UTF8);
                else
                begin
                    status = S_CLOSED;
                    phase = P_HDR1;
                    push_event(wsd_pkg::KIND_CLOSE, wsd_pkg::OP_CLOSE, 1'b1, 8'd0, 63'd0,
                               1'b0, wsd_pkg::ERR_NONE, len_cnt == 4'd2 ? code_acc : 16'd0);
                end
                return;
            end
        end
        if (last)
            phase = P_HDR1;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic rs);
        logic [3:0] op;
        if (rs)
        begin
            status = S_RUN;
            phase = P_HDR1;
            return;
        end
        if (status != S_RUN)
            return;
        case (phase)
            P_HDR1:
            begin
                hdr_first = {b[7], b[3:0]};
                if (b[6:4] != 3'd0)
                    parse_error(wsd_pkg::ERR_RSV);
                else
                    phase = P_HDR2;
            end
            P_HDR2:
            begin
                op = hdr_first[3:0];
                if (b[7] != srv_role)
                    parse_error(wsd_pkg::ERR_MASK);
                else if (!(op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_CLOSE ||
                           op == wsd_pkg::OP_PING || op == wsd_pkg::OP_PONG))
                    parse_error(wsd_pkg::ERR_OPCODE);
                else
                begin
                    len_acc = 64'd0;
                    len_cnt = 4'd0;
                    if (b[6:0] == 7'd126)
                        phase = P_EXT16;
                    else if (b[6:0] == 7'd127)
                        phase = P_EXT64;
                    else
                    begin
                        len_acc = {57'd0, b[6:0]};
                        check_header();
                    end
                end
            end
            P_EXT16:
            begin
                len_acc = {48'd0, len_acc[7:0], b};
                len_cnt = len_cnt + 4'd1;
                if (len_cnt == 4'd2)
                begin
                    if (len_acc < 64'd126)
                        parse_error(wsd_pkg::ERR_NONMINIMAL);
                    else
                        check_header();
                end
            end
            P_EXT64:
            begin
                if (len_cnt == 4'd0 && b[7])
                    parse_error(wsd_pkg::ERR_LEN_MSB);
                else
                begin
                    len_acc = {len_acc[55:0], b};
                    len_cnt = len_cnt + 4'd1;
                    if (len_cnt == 4'd8)
                    begin
                        if (len_acc <= 64'hffff)
                            parse_error(wsd_pkg::ERR_NONMINIMAL);
                        else
                            check_header();
                    end
                end
            end
            P_KEY:
            begin
                key = {key[23:0], b};
                len_cnt = len_cnt + 4'd1;
                if (len_cnt == 4'd4)
                    open_payload();
            end
            P_DATA: take_payload(b);
            default:
            begin
                phase = P_HDR1;
                predict_byte(b, rs);
            end
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b, logic rs);
        while (!tx_no_idle && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        restart <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, rs);
    endtask

    task automatic write_reg(logic idx, logic [62:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == wsd_pkg::CFG_ROLE)
            srv_role = val[0];
        else
            size_limit = val;
    endtask

    task automatic drain();
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [7:0] random_content(logic [3:0] op);
        if (op != wsd_pkg::OP_CLOSE || $urandom_range(3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    // Builds one frame into frame_bytes; mostly well formed, sometimes corrupted.
    task automatic build_frame();
        logic [3:0]  op;
        logic        fin;
        int          len;
        int          sel;
        logic [31:0] mk;
        logic [15:0] cc;
        logic [7:0]  plain[$];
        frame_bytes.delete();
        sel = $urandom_range(9);
        op = sel < 5 ? wsd_pkg::OP_TEXT : sel < 7 ? wsd_pkg::OP_CLOSE :
             sel < 8 ? wsd_pkg::OP_PING : wsd_pkg::OP_PONG;
        fin = 1'b1;
        len = $urandom_range(3) == 0 ? $urandom_range(126, 300) : $urandom_range(0, 24);
        if (op != wsd_pkg::OP_TEXT && len > 125)
            len = $urandom_range(0, 20);
        for (int i = 0; i < len; i++)
            plain = {plain, random_content(op)};
        if (op == wsd_pkg::OP_CLOSE && len >= 2)
        begin
            sel = $urandom_range(9);
            cc = sel < 6 ? 16'($urandom_range(1000, 1014)) :
                 sel < 8 ? 16'($urandom_range(3000, 4999)) : 16'($urandom);
            plain[0] = cc[15:8];
            plain[1] = cc[7:0];
        end
        if ($urandom_range(9) == 0)
        begin
            fin = $urandom_range(1);
            op = 4'($urandom);
        end
        frame_bytes = {frame_bytes, {fin, $urandom_range(15) == 0 ? 3'($urandom) : 3'd0, op}};
        mk = $urandom;
        sel = srv_role ^ ($urandom_range(19) == 0);
        if (len < 126)
            frame_bytes = {frame_bytes, {sel[0], 7'(len)}};
        else
        begin
            frame_bytes = {frame_bytes, {sel[0], 7'd126}};
            frame_bytes = {frame_bytes, 8'(len >> 8)};
            frame_bytes = {frame_bytes, 8'(len)};
        end
        if (srv_role)
            for (int i = 0; i < 4; i++)
                frame_bytes = {frame_bytes, mk[31 - 8 * i -: 8]};
        for (int i = 0; i < len; i++)
            frame_bytes = {frame_bytes,
                           plain[i] ^ (srv_role ? mk[31 - 8 * (i % 4) -: 8] : 8'd0)};
    endtask

    initial
    begin
        rx_hold = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold)
            begin
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                rx_hold = 1'b0;
            end
            else
                out_stall <= !rx_no_idle && $urandom_range(99) < 19;
        end
    end

    always @(posedge clk)
    begin
        wsd_pkg::res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected result kind %0d", kind);
                failures++;
            end
            else
            begin
                e = expected_events.pop_front();
                if (kind != e.kind)
                begin
                    $error("kind: expected %0d, actual %0d", e.kind, kind);
                    failures++;
                end
                if (opcode != e.opcode)
                begin
                    $error("opcode: expected %0d, actual %0d", e.opcode, opcode);
                    failures++;
                end
                if (final_flag != e.final_flag)
                begin
                    $error("final_flag: expected %0d, actual %0d", e.final_flag, final_flag);
                    failures++;
                end
                if (payload_byte != e.payload_byte)
                begin
                    $error("payload_byte: expected %0h, actual %0h", e.payload_byte,
                           payload_byte);
                    failures++;
                end
                if (frame_length != e.frame_length)
                begin
                    $error("frame_length: expected %0d, actual %0d", e.frame_length,
                           frame_length);
                    failures++;
                end
                if (last_of_frame != e.last_of_frame)
                begin
                    $error("last_of_frame: expected %0d, actual %0d", e.last_of_frame,
                           last_of_frame);
                    failures++;
                end
                if (error_code != e.error_code)
                begin
                    $error("error_code: expected %0d, actual %0d", e.error_code, error_code);
                    failures++;
                end
                if (close_status != e.close_status)
                begin
                    $error("close_status: expected %0d, actual %0d", e.close_status,
                           close_status);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        row_t       directed[$];
        logic [7:0] long_hdr[10];
        int         sent;
        int         mark;
        failures = 0;
        n_pushed = 0;
        rx_no_idle = 1'b0;
        tx_no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        restart = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = wsd_pkg::CFG_ROLE;
        cfg_data = 63'd0;
        srv_role = 1'b1;
        size_limit = 63'd8388608;
        phase = P_HDR1;
        status = S_RUN;
        hdr_first = 5'd0;
        len_acc = 64'd0;
        len_cnt = 4'd0;
        key = 32'd0;
        remain = 63'd0;
        key_idx = 2'd0;
        code_acc = 16'd0;
        u8_state = 4'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            '{8'hf1, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_RSV},
            '{8'h00, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h81, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_MASK},
            '{8'h00, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h82, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h80, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_OPCODE},
            '{8'h00, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h81, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'hff, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'hff, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_LEN_MSB},
            '{8'hff, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h81, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'hfe, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h00, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h7d, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_NONMINIMAL},
            '{8'h00, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h09, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h80, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_CONTROL},
            '{8'h00, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h01, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h80, 1'b0, 1'b1, wsd_pkg::KIND_ERROR, wsd_pkg::ERR_FRAG},
            '{8'h00, 1'b1, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h88, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE},
            '{8'h80, 1'b0, 1'b0, wsd_pkg::KIND_HEADER, wsd_pkg::ERR_NONE}
        };
        foreach (directed[i])
        begin
            mark = n_pushed;
            send_byte(directed[i].data, directed[i].rst);
            if (directed[i].has_exp)
            begin
                if (n_pushed != mark + 1)
                begin
                    $error("result count: expected 1, actual %0d", n_pushed - mark);
                    failures++;
                end
                else
                begin
                    if (expected_events[$].kind != directed[i].exp_kind)
                    begin
                        $error("kind: expected %0d, actual %0d", directed[i].exp_kind,
                               expected_events[$].kind);
                        failures++;
                    end
                    if (expected_events[$].error_code != directed[i].exp_err)
                    begin
                        $error("error_code: expected %0d, actual %0d", directed[i].exp_err,
                               expected_events[$].error_code);
                        failures++;
                    end
                end
            end
        end
        // The masking key of the empty close frame, then the closed state.
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom), 1'b0);
        send_byte(8'h00, 1'b1);
        in_valid <= 1'b0;
        drain();

        sent = 0;
        for (int phase_no = 0; phase_no < 4; phase_no++)
        begin
            write_reg(wsd_pkg::CFG_ROLE, phase_no % 2 == 0 ? 63'd0 : 63'd1);
            write_reg(wsd_pkg::CFG_MAX_LEN, phase_no == 0 ? 63'd1 :
                      phase_no == 1 ? 63'h7fffffffffffffff :
                      phase_no == 2 ? 63'd200 : 63'd8388608);
            tx_no_idle = phase_no == 1;
            rx_no_idle = phase_no == 1;
            while (sent < 275 * (phase_no + 1))
            begin
                if (status != S_RUN || $urandom_range(19) == 0)
                begin
                    send_byte(8'($urandom), 1'b1);
                    continue;
                end
                build_frame();
                if (phase_no == 2 && sent < 275 * phase_no + 150 && !rx_hold)
                    rx_hold = 1'b1;
                foreach (frame_bytes[i])
                begin
                    send_byte(frame_bytes[i], 1'b0);
                    sent++;
                    if (status != S_RUN && $urandom_range(1))
                        break;
                end
            end
            in_valid <= 1'b0;
            drain();
        end
        // A long explicit length in the 64-bit form hits the size limit.
        write_reg(wsd_pkg::CFG_ROLE, 63'd1);
        write_reg(wsd_pkg::CFG_MAX_LEN, 63'd1);
        long_hdr = '{8'h81, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        foreach (long_hdr[i])
            send_byte(long_hdr[i], 1'b0);
        send_byte(8'h00, 1'b1);
        in_valid <= 1'b0;
        drain();

        if (failures == 0)
            $display("websocket_frame_deframer regression: pass");
        else
            $display("websocket_frame_deframer regression: fail");
        $finish;
    end

endmodule
